// ===== hdl/ieee754_to_hex_float_text_unit_defines.svh =====
// Assertion helpers used by the top RTL module of the hexadecimal float text unit.
`ifndef IEEE754_TO_HEX_FLOAT_TEXT_UNIT_DEFINES_SVH
`define IEEE754_TO_HEX_FLOAT_TEXT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2HFT_ASSERT_SAME(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2HFT_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/i2hft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2hft_pkg;

    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] pc_t;

    // What a step puts on the output channel.
    typedef enum logic [1:0] {
        EM_NONE,
        EM_CONST,
        EM_HEX,
        EM_DEC
    } emit_t;

    // Datapath operation of a step.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_STRIP,
        OP_HEX_NEXT,
        OP_DAB_INIT,
        OP_DAB_STEP,
        OP_BCD_SHIFT
    } op_t;

    // Jump condition of a step.
    typedef enum logic [3:0] {
        CD_NEVER,
        CD_ALWAYS,
        CD_NAN,
        CD_INF,
        CD_NEG,
        CD_ZERO,
        CD_SUB,
        CD_DBL,
        CD_STRIP,
        CD_FRAC_ZERO,
        CD_HEX_MORE,
        CD_EXP_NEG,
        CD_DAB_MORE,
        CD_BCD_LEAD,
        CD_DEC_MORE
    } cond_t;

    typedef struct packed {
        emit_t      emit;
        logic [6:0] ch;
        logic       last;
        op_t        op;
        cond_t      cond;
        logic       inv;
        pc_t        target;
    } ctrl_word_t;

    // Status flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic nan;
        logic inf;
        logic neg;
        logic zero;
        logic sub;
        logic dbl;
        logic strip;
        logic frac_zero;
        logic hex_more;
        logic exp_neg;
        logic dab_more;
        logic bcd_lead;
        logic dec_more;
    } cond_flags_t;

    localparam logic [10:0] SGL_EXP_MAX = 11'h0FF;
    localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
    localparam logic [10:0] SGL_BIAS    = 11'd127;
    localparam logic [10:0] DBL_BIAS    = 11'd1023;
    localparam logic [3:0]  SGL_DIGITS  = 4'd6;
    localparam logic [3:0]  DBL_DIGITS  = 4'd13;
    localparam logic [3:0]  DAB_BITS    = 4'd10;
    localparam logic [2:0]  DEC_DIGITS  = 3'd4;

    // Program labels.
    localparam pc_t A_LOAD      = 6'd0;
    localparam pc_t A_SIGN_DONE = 6'd4;
    localparam pc_t A_LEAD_SUB  = 6'd11;
    localparam pc_t A_POINT     = 6'd12;
    localparam pc_t A_STRIP     = 6'd13;
    localparam pc_t A_FRAC      = 6'd15;
    localparam pc_t A_HEX       = 6'd18;
    localparam pc_t A_EXP       = 6'd19;
    localparam pc_t A_EXP_MAG   = 6'd23;
    localparam pc_t A_DAB       = 6'd24;
    localparam pc_t A_NORM      = 6'd25;
    localparam pc_t A_DEC       = 6'd27;
    localparam pc_t A_NAN       = 6'd29;
    localparam pc_t A_INF       = 6'd32;
    localparam pc_t A_ZERO      = 6'd40;
    localparam pc_t A_SUBEXP    = 6'd45;
    localparam pc_t A_SUBEXP_D  = 6'd51;

    function automatic ctrl_word_t mk(input emit_t e, input logic [7:0] c, input logic l,
                                      input op_t o, input cond_t cd, input logic iv,
                                      input pc_t t);
        ctrl_word_t w;
        w.emit   = e;
        w.ch     = c[6:0];
        w.last   = l;
        w.op     = o;
        w.cond   = cd;
        w.inv    = iv;
        w.target = t;
        return w;
    endfunction

    function automatic ctrl_word_t put(input logic [7:0] c);
        return mk(EM_CONST, c, 1'b0, OP_NONE, CD_NEVER, 1'b0, A_LOAD);
    endfunction

    // Final character of a fixed text; returns to the load step.
    function automatic ctrl_word_t put_end(input logic [7:0] c);
        return mk(EM_CONST, c, 1'b1, OP_NONE, CD_ALWAYS, 1'b0, A_LOAD);
    endfunction

    function automatic ctrl_word_t jmp(input cond_t cd, input logic iv, input pc_t t);
        return mk(EM_NONE, 8'h00, 1'b0, OP_NONE, cd, iv, t);
    endfunction

    function automatic ctrl_word_t act(input op_t o, input cond_t cd, input pc_t t);
        return mk(EM_NONE, 8'h00, 1'b0, o, cd, 1'b0, t);
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (7'h30 + {3'b000, d}) : (7'h57 + {3'b000, d});
    endfunction

    // Control store of the formatter.
    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        case (pc)
            6'd0:  w = act(OP_LOAD, CD_NEVER, A_LOAD);
            6'd1:  w = jmp(CD_NAN, 1'b0, A_NAN);
            6'd2:  w = jmp(CD_NEG, 1'b1, A_SIGN_DONE);
            6'd3:  w = put("-");
            6'd4:  w = jmp(CD_INF, 1'b0, A_INF);
            6'd5:  w = put("0");
            6'd6:  w = put("x");
            6'd7:  w = jmp(CD_ZERO, 1'b0, A_ZERO);
            6'd8:  w = jmp(CD_SUB, 1'b0, A_LEAD_SUB);
            6'd9:  w = put("1");
            6'd10: w = jmp(CD_ALWAYS, 1'b0, A_POINT);
            6'd11: w = put("0");
            6'd12: w = put(".");
            6'd13: w = jmp(CD_STRIP, 1'b1, A_FRAC);
            6'd14: w = act(OP_STRIP, CD_ALWAYS, A_STRIP);
            6'd15: w = jmp(CD_FRAC_ZERO, 1'b1, A_HEX);
            6'd16: w = put("0");
            6'd17: w = jmp(CD_ALWAYS, 1'b0, A_EXP);
            6'd18: w = mk(EM_HEX, 8'h00, 1'b0, OP_HEX_NEXT, CD_HEX_MORE, 1'b0, A_HEX);
            6'd19: w = jmp(CD_SUB, 1'b0, A_SUBEXP);
            6'd20: w = put("p");
            6'd21: w = jmp(CD_EXP_NEG, 1'b1, A_EXP_MAG);
            6'd22: w = put("-");
            6'd23: w = act(OP_DAB_INIT, CD_NEVER, A_LOAD);
            6'd24: w = act(OP_DAB_STEP, CD_DAB_MORE, A_DAB);
            6'd25: w = jmp(CD_BCD_LEAD, 1'b1, A_DEC);
            6'd26: w = act(OP_BCD_SHIFT, CD_ALWAYS, A_NORM);
            6'd27: w = mk(EM_DEC, 8'h00, 1'b0, OP_BCD_SHIFT, CD_DEC_MORE, 1'b0, A_DEC);
            6'd28: w = jmp(CD_ALWAYS, 1'b0, A_LOAD);
            6'd29: w = put("N");
            6'd30: w = put("a");
            6'd31: w = put_end("N");
            6'd32: w = put("I");
            6'd33: w = put("n");
            6'd34: w = put("f");
            6'd35: w = put("i");
            6'd36: w = put("n");
            6'd37: w = put("i");
            6'd38: w = put("t");
            6'd39: w = put_end("y");
            6'd40: w = put("0");
            6'd41: w = put(".");
            6'd42: w = put("0");
            6'd43: w = put("p");
            6'd44: w = put_end("0");
            6'd45: w = jmp(CD_DBL, 1'b0, A_SUBEXP_D);
            6'd46: w = put("p");
            6'd47: w = put("-");
            6'd48: w = put("1");
            6'd49: w = put("2");
            6'd50: w = put_end("6");
            6'd51: w = put("p");
            6'd52: w = put("-");
            6'd53: w = put("1");
            6'd54: w = put("0");
            6'd55: w = put("2");
            6'd56: w = put_end("2");
            default: w = jmp(CD_ALWAYS, 1'b0, A_LOAD);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/i2hft_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2hft_sequencer (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   hold,
    input  wire i2hft_pkg::cond_flags_t flags,
    output i2hft_pkg::ctrl_word_t       cw
);
    import i2hft_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic cond_hit;

    assign cw = rom_word(pc_reg);

    always_comb
    begin
        case (cw.cond)
            CD_NEVER:     cond_hit = 1'b0;
            CD_ALWAYS:    cond_hit = 1'b1;
            CD_NAN:       cond_hit = flags.nan;
            CD_INF:       cond_hit = flags.inf;
            CD_NEG:       cond_hit = flags.neg;
            CD_ZERO:      cond_hit = flags.zero;
            CD_SUB:       cond_hit = flags.sub;
            CD_DBL:       cond_hit = flags.dbl;
            CD_STRIP:     cond_hit = flags.strip;
            CD_FRAC_ZERO: cond_hit = flags.frac_zero;
            CD_HEX_MORE:  cond_hit = flags.hex_more;
            CD_EXP_NEG:   cond_hit = flags.exp_neg;
            CD_DAB_MORE:  cond_hit = flags.dab_more;
            CD_BCD_LEAD:  cond_hit = flags.bcd_lead;
            CD_DEC_MORE:  cond_hit = flags.dec_more;
            default:      cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (cond_hit ^ cw.inv)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= A_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ieee754_to_hex_float_text_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ieee754_to_hex_float_text_unit_defines.svh"

// Formats the raw bits of an IEEE-754 single or double value as hexadecimal
// text, one ASCII character per output item, with tlast on the final character
// of each value. Normal values read "[-]0x1.<frac>p<exp>" with a decimal
// exponent, subnormals "[-]0x0.<frac>p-126" or "[-]0x0.<frac>p-1022", zero
// "[-]0x0.0p0", and the specials "NaN", "Infinity" and "-Infinity". The fraction
// keeps its leading zeros but loses its trailing zero digits. A small
// microcoded sequencer runs one control step per clock while it neither waits
// for an input item nor for a stalled output. Its steps emit the characters,
// strip trailing zero digits, convert the ten bits of a normal exponent's
// magnitude to decimal and skip the leading zeros of its four decimal digits,
// with branch and setup steps between them. A new item is taken only once the
// previous one has handed its last character to the output register, and a
// stalled output holds the sequencer on its current character step.
module ieee754_to_hex_float_text_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] value_bits
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind (0 single, 1 double)
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic             m_axis_tlast    // last
);
    import i2hft_pkg::*;

    ctrl_word_t  cw;
    cond_flags_t flags;
    logic        hold;
    logic        out_free;
    logic        load;
    logic        step;

    // Working registers of the value being formatted.
    logic        neg_reg,     neg_next;
    logic        dbl_reg,     dbl_next;
    logic [10:0] expo_reg,    expo_next;
    logic [51:0] frac_reg,    frac_next;
    logic [3:0]  hex_cnt_reg, hex_cnt_next;
    logic [9:0]  bin_reg,     bin_next;
    logic [15:0] bcd_reg,     bcd_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [2:0]  dec_cnt_reg, dec_cnt_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  char_reg,      char_next;
    logic        last_reg,      last_next;

    logic [10:0] exp_max;
    logic [10:0] bias;
    logic [10:0] exp_mag;
    logic [3:0]  hex_idx;
    logic [5:0]  nib_base;
    logic [3:0]  nibble;
    logic [15:0] bcd_adj;
    logic [6:0]  emit_char;
    logic        emit_last;

    i2hft_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .hold  (hold),
        .flags (flags),
        .cw    (cw)
    );

    // The output register takes a new character when empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (cw.op == OP_LOAD);
    assign hold          = ((cw.op == OP_LOAD) && !s_axis_tvalid)
                        || ((cw.emit != EM_NONE) && !out_free);
    assign step          = !hold;
    assign load          = s_axis_tvalid && s_axis_tready;

    assign exp_max = dbl_reg ? DBL_EXP_MAX : SGL_EXP_MAX;
    assign bias    = dbl_reg ? DBL_BIAS : SGL_BIAS;
    assign exp_mag = (expo_reg < bias) ? (bias - expo_reg) : (expo_reg - bias);

    always_comb
    begin
        flags.nan       = (expo_reg == exp_max) && (frac_reg != '0);
        flags.inf       = (expo_reg == exp_max) && (frac_reg == '0);
        flags.neg       = neg_reg;
        flags.zero      = (expo_reg == '0) && (frac_reg == '0);
        flags.sub       = (expo_reg == '0);
        flags.dbl       = dbl_reg;
        flags.strip     = (frac_reg != '0) && (frac_reg[3:0] == 4'h0);
        flags.frac_zero = (frac_reg == '0);
        flags.hex_more  = (hex_cnt_reg > 4'd1);
        flags.exp_neg   = (expo_reg < bias);
        flags.dab_more  = (bit_cnt_reg > 4'd1);
        flags.bcd_lead  = (bcd_reg[15:12] == 4'h0) && (dec_cnt_reg > 3'd1);
        flags.dec_more  = (dec_cnt_reg > 3'd1);
    end

    // The leading hex digit sits at nibble position hex_cnt - 1.
    assign hex_idx  = hex_cnt_reg - 4'd1;
    assign nib_base = {hex_idx, 2'b00};
    assign nibble   = frac_reg[nib_base +: 4];

    // Double-dabble correction: every BCD digit of five or more gets three added.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? (bcd_reg[4*i +: 4] + 4'd3)
                                                             : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        case (cw.emit)
            EM_CONST: emit_char = cw.ch;
            EM_HEX:   emit_char = hex_char(nibble);
            EM_DEC:   emit_char = 7'h30 + {3'b000, bcd_reg[15:12]};
            default:  emit_char = cw.ch;
        endcase
        emit_last = cw.last || ((cw.emit == EM_DEC) && (dec_cnt_reg == 3'd1));
    end

    always_comb
    begin
        neg_next     = neg_reg;
        dbl_next     = dbl_reg;
        expo_next    = expo_reg;
        frac_next    = frac_reg;
        hex_cnt_next = hex_cnt_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dec_cnt_next = dec_cnt_reg;
        if (step)
        begin
            case (cw.op)
                OP_LOAD:
                begin
                    dbl_next = s_axis_tuser[0];
                    if (s_axis_tuser[0])
                    begin
                        neg_next     = s_axis_tdata[63];
                        expo_next    = s_axis_tdata[62:52];
                        frac_next    = s_axis_tdata[51:0];
                        hex_cnt_next = DBL_DIGITS;
                    end
                    else
                    begin
                        // The 23-bit single fraction is padded to six whole digits.
                        neg_next     = s_axis_tdata[31];
                        expo_next    = {3'b000, s_axis_tdata[30:23]};
                        frac_next    = {28'h0000000, s_axis_tdata[22:0], 1'b0};
                        hex_cnt_next = SGL_DIGITS;
                    end
                end
                OP_STRIP:
                begin
                    frac_next    = {4'h0, frac_reg[51:4]};
                    hex_cnt_next = hex_cnt_reg - 4'd1;
                end
                OP_HEX_NEXT:
                begin
                    hex_cnt_next = hex_cnt_reg - 4'd1;
                end
                OP_DAB_INIT:
                begin
                    bin_next     = exp_mag[9:0];
                    bcd_next     = '0;
                    bit_cnt_next = DAB_BITS;
                    dec_cnt_next = DEC_DIGITS;
                end
                OP_DAB_STEP:
                begin
                    bcd_next     = {bcd_adj[14:0], bin_reg[9]};
                    bin_next     = {bin_reg[8:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - 4'd1;
                end
                OP_BCD_SHIFT:
                begin
                    bcd_next     = {bcd_reg[11:0], 4'h0};
                    dec_cnt_next = dec_cnt_reg - 3'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if ((cw.emit != EM_NONE) && out_free)
        begin
            out_valid_next = 1'b1;
            char_next      = emit_char;
            last_next      = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        dbl_reg     <= dbl_next;
        expo_reg    <= expo_next;
        frac_reg    <= frac_next;
        hex_cnt_reg <= hex_cnt_next;
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dec_cnt_reg <= dec_cnt_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, char_reg};
    assign m_axis_tlast  = last_reg;

    // A hex digit is only printed while the digit counter points inside the fraction.
    `I2HFT_ASSERT_SAME(a_hex_digit_range, clk, rst_n, (cw.emit == EM_HEX), (hex_cnt_reg != 4'd0) && (hex_cnt_reg <= DBL_DIGITS), "hex digit counter out of range")
    // A decimal digit comes from a valid BCD digit with digits left to print.
    `I2HFT_ASSERT_SAME(a_dec_digit_valid, clk, rst_n, (cw.emit == EM_DEC), (dec_cnt_reg != 3'd0) && (bcd_reg[15:12] <= 4'd9), "bad decimal exponent digit")
    // Once an item is taken the sequencer leaves the load step.
    `I2HFT_ASSERT_NEXT(a_busy_after_load, clk, rst_n, load, !s_axis_tready, "input accepted twice in a row")

endmodule

`default_nettype wire

// ===== sim/ieee754_to_hex_float_text_unit_check.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the formatter. Every value taken on the input
// channel is rendered here into the characters it must produce, and each
// character leaving the block is compared with the oldest one still owed.
module ieee754_to_hex_float_text_unit_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          error_count,
    output int          chars_pending
);

    // Mismatch lines are capped so that a badly broken block cannot flood the log.
    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    text_char_t   owed_chars[$];
    byte unsigned text_buf[$];
    int           mismatch_total = 0;
    int           owed_total     = 0;

    assign error_count   = mismatch_total;
    assign chars_pending = owed_total;

    task automatic report_mismatch(input string msg);
        if (mismatch_total < REPORT_CAP)
        begin
            $display("%0t ns: MISMATCH: %s", $realtime, msg);
        end
        mismatch_total++;
    endtask

    function automatic void add_text(input string t);
        for (int i = 0; i < t.len(); i++)
        begin
            text_buf.push_back(t[i]);
        end
    endfunction

    // Renders one value into text_buf, then moves it to the owed characters.
    function automatic void render_value(input logic dbl, input logic [63:0] raw);
        logic        neg;
        logic [10:0] expo;
        logic [10:0] emax;
        int          bias;
        logic [63:0] frac;
        int          digits;
        logic [3:0]  nib;
        text_char_t  c;

        text_buf.delete();
        if (dbl)
        begin
            neg    = raw[63];
            expo   = raw[62:52];
            emax   = 11'h7FF;
            bias   = 1023;
            frac   = {12'd0, raw[51:0]};
            digits = 13;
        end
        else
        begin
            // The upper word is ignored; the 23-bit fraction is padded to six digits.
            neg    = raw[31];
            expo   = {3'd0, raw[30:23]};
            emax   = 11'h0FF;
            bias   = 127;
            frac   = {40'd0, raw[22:0], 1'b0};
            digits = 6;
        end

        if (expo == emax)
        begin
            if (frac != 64'd0)
                add_text("NaN");
            else if (neg)
                add_text("-Infinity");
            else
                add_text("Infinity");
        end
        else if (expo == 11'd0 && frac == 64'd0)
        begin
            if (neg)
                add_text("-0x0.0p0");
            else
                add_text("0x0.0p0");
        end
        else
        begin
            if (neg)
                add_text("-");
            add_text("0x");
            if (expo == 11'd0)
                add_text("0.");
            else
                add_text("1.");
            // Trailing zero digits go, leading ones stay.
            while (frac != 64'd0 && frac[3:0] == 4'd0)
            begin
                frac = frac >> 4;
                digits--;
            end
            if (frac == 64'd0)
            begin
                add_text("0");
            end
            else
            begin
                for (int i = digits - 1; i >= 0; i--)
                begin
                    nib = frac[4*i +: 4];
                    text_buf.push_back((nib < 4'd10) ? (8'h30 + nib) : (8'h57 + nib));
                end
            end
            if (expo == 11'd0)
            begin
                if (dbl)
                    add_text("p-1022");
                else
                    add_text("p-126");
            end
            else
            begin
                add_text("p");
                add_text($sformatf("%0d", int'(expo) - bias));
            end
        end

        for (int i = 0; i < text_buf.size(); i++)
        begin
            c.code = text_buf[i][6:0];
            c.last = (i == text_buf.size() - 1);
            owed_chars.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin : watch_channels
        text_char_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                render_value(s_axis_tuser[0], s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_chars.size() == 0)
                begin
                    report_mismatch($sformatf("character 0x%02h (last %0b) with none owed",
                                              m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    want = owed_chars.pop_front();
                    if (m_axis_tdata !== {1'b0, want.code} || m_axis_tlast !== want.last)
                    begin
                        report_mismatch($sformatf(
                            "got char 0x%02h last %0b, expected char 0x%02h last %0b",
                            m_axis_tdata, m_axis_tlast, {1'b0, want.code}, want.last));
                    end
                end
            end
        end
        owed_total <= owed_chars.size();
    end

endmodule

// ===== sim/ieee754_to_hex_float_text_unit_test.sv =====
`timescale 1ns / 1ps

// Top of the formatter testbench. It generates clock and reset, drives values
// into the block, stalls the character output at random, and gives the verdict.
// All checking of the characters happens in the checker instance beside the block.
module ieee754_to_hex_float_text_unit_test;

    // No item may take this many cycles without either channel moving.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last character, well beyond the slowest item.
    localparam int SETTLE_CYCLES  = 100;
    localparam int RESET_CYCLES   = 5;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = 64'd0;
    logic [0:0]  s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int mismatches;
    int chars_pending;

    // Percentages of cycles in which the sender holds off and the receiver stalls.
    int send_idle_pct = 9;
    int recv_idle_pct = 63;
    int quiet_cycles  = 0;

    always #10 clk = ~clk;

    ieee754_to_hex_float_text_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ieee754_to_hex_float_text_unit_check i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (mismatches),
        .chars_pending (chars_pending)
    );

    // The receiver decides afresh every cycle whether it takes a character.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // The watchdog restarts whenever an item moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one value and returns at the edge where the block takes it. The gap
    // is counted up front so that tvalid gets a single assignment per edge.
    task automatic send_value(input logic dbl, input logic [63:0] raw);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= dbl;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // Holds the input off until every owed character has left the block. The
    // checker's count is registered, hence the wait for an edge before looking at it.
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (chars_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random values, weighted toward the shapes that take the block off its
    // common path: specials, tiny values, fractions with many trailing zero
    // digits and exponents close to zero. The rest are plain random patterns.
    task automatic random_value(output logic dbl, output logic [63:0] raw);
        int pick;
        int zeros;
        dbl  = $urandom_range(0, 1);
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 1)
        begin
            // All-ones exponent: NaN, or infinity when the fraction is cleared.
            if (dbl)
                raw[62:52] = '1;
            else
                raw[30:23] = '1;
            if ($urandom_range(0, 1) == 0)
            begin
                if (dbl)
                    raw[51:0] = '0;
                else
                    raw[22:0] = '0;
            end
        end
        else if (pick < 3)
        begin
            // Zero exponent: subnormal, or signed zero now and then.
            if (dbl)
                raw[62:52] = '0;
            else
                raw[30:23] = '0;
            if ($urandom_range(0, 3) == 0)
            begin
                if (dbl)
                    raw[51:0] = '0;
                else
                    raw[22:0] = '0;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                zeros = dbl ? $urandom_range(1, 51) : $urandom_range(1, 22);
                raw   = raw & ~((64'd1 << zeros) - 64'd1);
            end
        end
        else if (pick < 6)
        begin
            // Clear low fraction bits so that many trailing zero digits get stripped.
            zeros = dbl ? $urandom_range(1, 52) : $urandom_range(1, 23);
            raw   = raw & ~((64'd1 << zeros) - 64'd1);
        end
        else if (pick < 7)
        begin
            // Exponents around zero, both signs and magnitudes up to ten.
            if (dbl)
                raw[62:52] = 11'd1013 + 11'($urandom_range(0, 20));
            else
                raw[30:23] = 8'd117 + 8'($urandom_range(0, 20));
        end
    endtask

    task automatic send_random_values(input int count, input bit pause_midway);
        logic        dbl;
        logic [63:0] raw;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
            begin
                drain_outputs();
            end
            random_value(dbl, raw);
            send_value(dbl, raw);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: a sender that rarely idles against a receiver that mostly
        // stalls. It opens with the directed values.

        // Single precision: zeros, infinities, NaNs of either sign, the normal and
        // subnormal extremes, a fraction that strips down to a few digits and a
        // value whose ignored upper word is full of ones.
        send_value(1'b0, 64'h0000_0000_0000_0000);
        send_value(1'b0, 64'h0000_0000_8000_0000);
        send_value(1'b0, 64'h0000_0000_7F80_0000);
        send_value(1'b0, 64'h0000_0000_FF80_0000);
        send_value(1'b0, 64'h0000_0000_7FC0_0000);
        send_value(1'b0, 64'h0000_0000_FFFF_FFFF);
        send_value(1'b0, 64'h0000_0000_3F80_0000);
        send_value(1'b0, 64'h0000_0000_C000_0000);
        send_value(1'b0, 64'h0000_0000_7F7F_FFFF);
        send_value(1'b0, 64'h0000_0000_0080_0000);
        send_value(1'b0, 64'h0000_0000_0000_0001);
        send_value(1'b0, 64'h0000_0000_807F_FFFF);
        send_value(1'b0, 64'hFFFF_FFFF_3F80_0100);

        // Double precision: zeros, infinities and a NaN, then the exponent extremes
        // (four-digit magnitudes of both signs) and a lone low fraction bit.
        send_value(1'b1, 64'h0000_0000_0000_0000);
        send_value(1'b1, 64'h8000_0000_0000_0000);
        send_value(1'b1, 64'h7FF0_0000_0000_0000);
        send_value(1'b1, 64'hFFF0_0000_0000_0000);
        send_value(1'b1, 64'h7FF0_0000_0000_0001);
        send_value(1'b1, 64'h3FF0_0000_0000_0000);
        send_value(1'b1, 64'h8010_0000_0000_0000);
        send_value(1'b1, 64'h7FEF_FFFF_FFFF_FFFF);
        send_value(1'b1, 64'h0000_0000_0000_0001);
        send_value(1'b1, 64'h800F_FFFF_FFFF_FFFF);
        send_value(1'b1, 64'hBFE0_1234_5000_0000);
        send_value(1'b1, 64'h3FF0_0000_0000_0010);

        send_random_values(135, 1'b1);
        drain_outputs();

        // Phase two: the roles swap, so the block mostly waits for input.
        send_idle_pct = 63;
        recv_idle_pct = 9;
        send_random_values(135, 1'b0);
        drain_outputs();

        // Phase three: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_values(134, 1'b0);

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && chars_pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
